/* hdl/tdjat_pkg.sv */
// shared types and codes for the time-of-day job alarm table
`default_nettype none

package tdjat_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    // action codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // job kinds
    localparam logic [1:0] KIND_ONCE   = 2'd0;
    localparam logic [1:0] KIND_DAILY  = 2'd1;
    localparam logic [1:0] KIND_HOURLY = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FIRED    = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    typedef struct packed {
        logic [7:0] tag;
        logic [1:0] kind;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic step_ok;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/tdjat_ctrl.sv */
// sequencer for add, remove and tick transactions
`default_nettype none

module tdjat_ctrl
    import tdjat_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_action,
    output logic            o_stall,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_stat   i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   w_accept;

    assign w_accept = i_valid && !r_stall;
    assign o_stall  = r_stall;

    always_comb begin
        o_cmd.start  = w_accept;
        o_cmd.step   = (r_state == S_WALK) && !i_stat.walk_done && i_stat.step_ok;
        o_cmd.finish = (r_state == S_FINISH) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_ADD) begin
                        n_state = S_FINISH;
                    end else if (i_action == ACT_REMOVE || i_action == ACT_TICK) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

endmodule

`default_nettype wire

/* hdl/tdjat_dp.sv */
// job table memory, walk pointers, match logic and result register
`default_nettype none

module tdjat_dp
    import tdjat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_job_tag,
    input  wire logic [1:0] i_job_kind,
    input  wire logic [4:0] i_hour_value,
    input  wire logic [5:0] i_minute_value,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic [7:0]      o_fired_tag,
    output logic            o_last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_entry          r_mem [TABLE_DEPTH];
    t_entry          r_rd_data;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_w;
    logic [1:0]      r_act;
    logic [7:0]      r_tag;
    logic [1:0]      r_kind;
    logic [4:0]      r_hour;
    logic [5:0]      r_min;
    logic            r_pend_valid;
    logic [7:0]      r_pend_tag;
    logic            r_any;
    logic            r_out_valid;
    logic [2:0]      r_out_status;
    logic [7:0]      r_out_tag;
    logic            r_out_last;

    logic [CW-1:0]   w_idx_inc;
    logic [IW-1:0]   w_rd_addr;
    logic            w_is_tick;
    logic            w_hour_eq;
    logic            w_hm_eq;
    logic            w_fire;
    logic            w_drop;
    logic            w_out_free;
    logic            w_step_emit;
    logic            w_emit;
    logic            w_add_room;
    logic [2:0]      w_emit_status;
    logic [7:0]      w_emit_tag;
    logic            w_emit_last;
    t_entry          w_new_entry;

    assign w_idx_inc = r_idx + CW'(1);
    assign w_rd_addr = i_cmd.start ? '0 :
                       i_cmd.step  ? w_idx_inc[IW-1:0] : r_idx[IW-1:0];

    assign w_is_tick = (r_act == ACT_TICK);
    assign w_hour_eq = (r_rd_data.hour == r_hour);
    assign w_hm_eq   = w_hour_eq && (r_rd_data.minute == r_min);

    always_comb begin
        case (r_rd_data.kind)
            KIND_ONCE, KIND_DAILY: w_fire = w_hm_eq;
            KIND_HOURLY:           w_fire = w_hour_eq;
            default:               w_fire = 1'b0;
        endcase
    end

    // tick drops matching once jobs, remove drops matching tags
    assign w_drop = w_is_tick ? ((r_rd_data.kind == KIND_ONCE) && w_hm_eq)
                              : (r_rd_data.tag == r_tag);

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_add_room  = (r_count < DEPTH_C);
    // a new firing releases the held one, which then is not the last
    assign w_step_emit = i_cmd.step && w_is_tick && w_fire && r_pend_valid;
    assign w_emit      = w_step_emit || i_cmd.finish;

    assign w_new_entry.tag    = r_tag;
    assign w_new_entry.kind   = r_kind;
    assign w_new_entry.hour   = r_hour;
    assign w_new_entry.minute = r_min;

    always_comb begin
        w_emit_status = ST_FIRED;
        w_emit_tag    = r_pend_tag;
        w_emit_last   = 1'b1;
        if (w_step_emit) begin
            w_emit_last = 1'b0;
        end else begin
            case (r_act)
                ACT_ADD: begin
                    w_emit_status = w_add_room ? ST_ADDED : ST_FULL;
                    w_emit_tag    = r_tag;
                end
                ACT_REMOVE: begin
                    w_emit_status = r_any ? ST_REMOVED : ST_NOTFOUND;
                    w_emit_tag    = r_tag;
                end
                default: begin
                    if (!r_pend_valid) begin
                        w_emit_status = ST_NONE;
                        w_emit_tag    = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_stat.walk_done = (r_idx == r_count);
        o_stat.out_free  = w_out_free;
        o_stat.step_ok   = !(w_is_tick && w_fire && r_pend_valid && !w_out_free);
    end

    // table memory: at most one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && !w_drop) begin
            r_mem[r_w[IW-1:0]] <= r_rd_data;
        end else if (i_cmd.finish && r_act == ACT_ADD && w_add_room) begin
            r_mem[r_count[IW-1:0]] <= w_new_entry;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // transaction fields and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act  <= i_action;
            r_tag  <= i_job_tag;
            r_kind <= i_job_kind;
            r_hour <= i_hour_value;
            r_min  <= i_minute_value;
            r_any  <= 1'b0;
        end else if (i_cmd.step) begin
            if (!w_is_tick && w_drop) begin
                r_any <= 1'b1;
            end
        end
        if (i_cmd.step && w_is_tick && w_fire) begin
            r_pend_tag <= r_rd_data.tag;
        end
        if (w_emit) begin
            r_out_status <= w_emit_status;
            r_out_tag    <= w_emit_tag;
            r_out_last   <= w_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_idx        <= '0;
            r_w          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // walk pointers: read index and compaction write index
            if (i_cmd.start) begin
                r_idx <= '0;
                r_w   <= '0;
            end else if (i_cmd.step) begin
                r_idx <= w_idx_inc;
                if (!w_drop) begin
                    r_w <= r_w + CW'(1);
                end
            end
            if (i_cmd.start) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && w_is_tick && w_fire) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_act == ACT_ADD) begin
                    if (w_add_room) begin
                        r_count <= r_count + CW'(1);
                    end
                end else begin
                    r_count <= r_w;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_fired_tag = r_out_tag;
    assign o_last      = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("job count above table depth");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w <= r_idx)
        else $error("compaction write pointer passed read pointer");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result emitted over a stalled result");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (o_valid && o_last))
        else $error("closing result not marked last");

endmodule

`default_nettype wire

/* hdl/time_of_day_job_alarm_table.sv */
// Time-of-day job alarm table, top level.
// Input channel (i_valid / o_stall) takes one transaction: add a job, remove
// all jobs with a tag, or a time tick. Output channel (o_valid / i_stall)
// returns result transactions; the final one for each input has o_last set.
// Add: accept goes straight to the finish state, which loads the result. Remove
// and tick: the table is walked one entry a cycle through a registered read of
// the job memory, except while the walk waits on a stalled result; the finish
// state then loads the final result.
// A tick emits one result per firing job in table order, or one none-fired
// result. Unused action code 3 is accepted and dropped with no result.
// One input is processed at a time; o_stall is registered: it rises after an
// add, remove or tick is accepted and falls after its final result is loaded
// into the output register.
// When the receiver stalls, the output register holds its result and the
// walk waits whenever another result is ready to go out.
// Reset clears the job count, the result register valid and the sequencer;
// the job memory itself is not cleared.
`default_nettype none

module time_of_day_job_alarm_table
    import tdjat_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_job_tag,
    input  wire logic [1:0] i_job_kind,
    input  wire logic [4:0] i_hour_value,
    input  wire logic [5:0] i_minute_value,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic [7:0]      o_fired_tag,
    output logic            o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tdjat_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    tdjat_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_action       (i_action),
        .i_job_tag      (i_job_tag),
        .i_job_kind     (i_job_kind),
        .i_hour_value   (i_hour_value),
        .i_minute_value (i_minute_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_fired_tag    (o_fired_tag),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
